// File: rtl/h2r_pkg.sv
// Shared types and constants for the HSV to RGB converter pipeline.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package h2r_pkg;

    localparam logic [7:0]  FULL_LEVEL   = 8'd255;
    localparam logic [16:0] FULL_SQUARED = 17'd65025;

    // floor(n / 65025) for n < 2**24 equals (n * RECIP_M) >> RECIP_SHIFT exactly.
    localparam logic [24:0] RECIP_M      = 25'd16909061;
    localparam int          RECIP_SHIFT  = 40;

    // Register stages from an accepted transfer to its result strobe.
    localparam int          PIPE_DEPTH   = 6;

    // Hue sectors, named by the colours at their two ends.
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    typedef struct packed {
        logic       valid;
        sector_t    sector;
        logic [7:0] frac;
        logic [7:0] sat;
        logic [7:0] val;
    } sector_stage_t;

    typedef struct packed {
        logic       valid;
        sector_t    sector;
        logic [7:0] val;
        logic [7:0] low;
        logic [7:0] fall;
        logic [7:0] rise;
    } levels_stage_t;

endpackage

// File: rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: six-stage pipeline.
// Depends on h2r_pkg, h2r_sector, h2r_levels and h2r_mapper.
`timescale 1ns / 1ps

// Channel   Handshake      Payload
// input     start / busy   hue, saturation, brightness
// result    done           red, green, blue
//
// A transfer is taken whenever start is high and busy is low; busy never rises,
// so a pixel can enter on every clock.
// Each result appears on done and the colour ports for one cycle, once its input
// transfer has passed through the six register stages of the arithmetic.
// Reset clears only the valid bits, so no result is strobed after reset until a
// new transfer has passed through.

module hsv_to_rgb_converter
    import h2r_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] hue,
    input  logic [7:0] saturation,
    input  logic [7:0] brightness,
    output logic       done,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    sector_stage_t sector_stage;
    levels_stage_t levels_stage;
    logic          load;

    assign busy = 1'b0;
    assign load = start && !busy;

    h2r_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .stage      (sector_stage)
    );

    h2r_levels u_levels (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stage  (sector_stage),
        .out_stage (levels_stage)
    );

    h2r_mapper u_mapper (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_stage (levels_stage),
        .done     (done),
        .red      (red),
        .green    (green),
        .blue     (blue)
    );

`ifndef NO_ASSERTIONS
    // Every accepted transfer comes out exactly once, a fixed latency later.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##PIPE_DEPTH done)
        else $error("accepted transfer did not produce a result on time");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result strobed without a matching input transfer");

    // Zero saturation must come out as grey at the value level.
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(saturation == 8'd0, PIPE_DEPTH)
        |-> red == $past(brightness, PIPE_DEPTH) && green == red && blue == red)
        else $error("grey pixel did not give equal channels at the value level");

    // One channel always carries the value level itself.
    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> red == $past(brightness, PIPE_DEPTH)
              || green == $past(brightness, PIPE_DEPTH)
              || blue == $past(brightness, PIPE_DEPTH))
        else $error("no channel equals the value level");
`endif

endmodule

// File: rtl/h2r_sector.sv
// First pipeline stage: splits the hue into a sector and a fraction.
// Depends on h2r_pkg.
`timescale 1ns / 1ps

module h2r_sector
    import h2r_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic [7:0]    hue,
    input  logic [7:0]    saturation,
    input  logic [7:0]    brightness,
    output sector_stage_t stage
);

    logic [10:0]   scaled;
    logic [10:0]   base;
    sector_t       sector_next;
    logic [10:0]   diff;
    logic          valid_reg;
    sector_t       sector_reg;
    logic [7:0]    frac_reg;
    logic [7:0]    sat_reg;
    logic [7:0]    val_reg;

    // 6 * hue as two shifts and an add.
    assign scaled = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    // Full-scale hue falls on the last threshold and wraps to the red sector.
    always_comb
    begin
        priority if (scaled >= 11'd1530)
        begin
            sector_next = SEC_R_TO_Y;
            base        = 11'd1530;
        end
        else if (scaled >= 11'd1275)
        begin
            sector_next = SEC_M_TO_R;
            base        = 11'd1275;
        end
        else if (scaled >= 11'd1020)
        begin
            sector_next = SEC_B_TO_M;
            base        = 11'd1020;
        end
        else if (scaled >= 11'd765)
        begin
            sector_next = SEC_C_TO_B;
            base        = 11'd765;
        end
        else if (scaled >= 11'd510)
        begin
            sector_next = SEC_G_TO_C;
            base        = 11'd510;
        end
        else if (scaled >= 11'd255)
        begin
            sector_next = SEC_Y_TO_G;
            base        = 11'd255;
        end
        else
        begin
            sector_next = SEC_R_TO_Y;
            base        = 11'd0;
        end
    end

    assign diff = scaled - base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg <= sector_next;
        frac_reg   <= diff[7:0];
        sat_reg    <= saturation;
        val_reg    <= brightness;
    end

    assign stage.valid  = valid_reg;
    assign stage.sector = sector_reg;
    assign stage.frac   = frac_reg;
    assign stage.sat    = sat_reg;
    assign stage.val    = val_reg;

endmodule

// File: rtl/h2r_levels.sv
// Stages two to five: forms the low, falling and rising channel levels
// with exact integer arithmetic. Depends on h2r_pkg.
`timescale 1ns / 1ps

module h2r_levels
    import h2r_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  sector_stage_t in_stage,
    output levels_stage_t out_stage
);

    // Stage two: the three 8 by 8 products.
    logic [7:0]  inv_frac;
    logic [7:0]  inv_sat;
    logic        valid2_reg;
    sector_t     sector2_reg;
    logic [7:0]  val2_reg;
    logic [15:0] pf2_reg;
    logic [15:0] pr2_reg;
    logic [15:0] pl2_reg;

    // Stage three: complements of the square, and the low level.
    logic [23:0] low_sum;
    logic        valid3_reg;
    sector_t     sector3_reg;
    logic [7:0]  val3_reg;
    logic [16:0] nf3_reg;
    logic [16:0] nr3_reg;
    logic [7:0]  low3_reg;

    // Stage four: scale by the value level.
    logic        valid4_reg;
    sector_t     sector4_reg;
    logic [7:0]  val4_reg;
    logic [23:0] mf4_reg;
    logic [23:0] mr4_reg;
    logic [7:0]  low4_reg;

    // Stage five: divide by 65025 through the reciprocal.
    logic [48:0] qf_prod;
    logic [48:0] qr_prod;
    logic        valid5_reg;
    sector_t     sector5_reg;
    logic [7:0]  val5_reg;
    logic [7:0]  fall5_reg;
    logic [7:0]  rise5_reg;
    logic [7:0]  low5_reg;

    assign inv_frac = FULL_LEVEL - in_stage.frac;
    assign inv_sat  = FULL_LEVEL - in_stage.sat;

    // y / 255 is exact as (257 * y + 257) >> 16 for any 16-bit y up to 65025.
    assign low_sum = {pl2_reg, 8'h00} + {8'h00, pl2_reg} + 24'd257;

    assign qf_prod = 49'(mf4_reg) * 49'(RECIP_M);
    assign qr_prod = 49'(mr4_reg) * 49'(RECIP_M);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else
        begin
            valid2_reg <= in_stage.valid;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
            valid5_reg <= valid4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sector2_reg <= in_stage.sector;
        val2_reg    <= in_stage.val;
        pf2_reg     <= 16'(in_stage.sat) * 16'(in_stage.frac);
        pr2_reg     <= 16'(in_stage.sat) * 16'(inv_frac);
        pl2_reg     <= 16'(in_stage.val) * 16'(inv_sat);

        sector3_reg <= sector2_reg;
        val3_reg    <= val2_reg;
        nf3_reg     <= FULL_SQUARED - {1'b0, pf2_reg};
        nr3_reg     <= FULL_SQUARED - {1'b0, pr2_reg};
        low3_reg    <= low_sum[23:16];

        sector4_reg <= sector3_reg;
        val4_reg    <= val3_reg;
        mf4_reg     <= 24'(25'(val3_reg) * 25'(nf3_reg));
        mr4_reg     <= 24'(25'(val3_reg) * 25'(nr3_reg));
        low4_reg    <= low3_reg;

        sector5_reg <= sector4_reg;
        val5_reg    <= val4_reg;
        fall5_reg   <= qf_prod[RECIP_SHIFT +: 8];
        rise5_reg   <= qr_prod[RECIP_SHIFT +: 8];
        low5_reg    <= low4_reg;
    end

    assign out_stage.valid  = valid5_reg;
    assign out_stage.sector = sector5_reg;
    assign out_stage.val    = val5_reg;
    assign out_stage.low    = low5_reg;
    assign out_stage.fall   = fall5_reg;
    assign out_stage.rise   = rise5_reg;

endmodule

// File: rtl/h2r_mapper.sv
// Last stage: assigns the value, low, falling and rising levels to the
// three colour channels by sector and registers the result. Depends on h2r_pkg.
`timescale 1ns / 1ps

module h2r_mapper
    import h2r_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  levels_stage_t in_stage,
    output logic          done,
    output logic [7:0]    red,
    output logic [7:0]    green,
    output logic [7:0]    blue
);

    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic       done_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    always_comb
    begin
        unique case (in_stage.sector)
            SEC_R_TO_Y:
            begin
                red_next   = in_stage.val;
                green_next = in_stage.rise;
                blue_next  = in_stage.low;
            end
            SEC_Y_TO_G:
            begin
                red_next   = in_stage.fall;
                green_next = in_stage.val;
                blue_next  = in_stage.low;
            end
            SEC_G_TO_C:
            begin
                red_next   = in_stage.low;
                green_next = in_stage.val;
                blue_next  = in_stage.rise;
            end
            SEC_C_TO_B:
            begin
                red_next   = in_stage.low;
                green_next = in_stage.fall;
                blue_next  = in_stage.val;
            end
            SEC_B_TO_M:
            begin
                red_next   = in_stage.rise;
                green_next = in_stage.low;
                blue_next  = in_stage.val;
            end
            default:
            begin
                red_next   = in_stage.val;
                green_next = in_stage.low;
                blue_next  = in_stage.fall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule
